// ----- hw/rtl/lsbg_pkg.sv -----
package lsbg_pkg;

   // Field widths of the item and of the configuration registers.
   localparam int DELTA_W  = 8;
   localparam int PHASE_W  = 16;
   localparam int FRAC_W   = 4;
   localparam int COORD_W  = 16;
   localparam int XBASE_W  = 10;
   localparam int YBASE_W  = 9;
   localparam int MOD_W    = 10;
   localparam int SPAN_W   = 10;
   localparam int COUNT_W  = 9;
   localparam int SIZE_W   = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SOURCE_X_BASE = 3'd0,
      REG_SOURCE_Y_BASE = 3'd1,
      REG_WRAP_MODULUS  = 3'd2,
      REG_TOTAL_SPAN    = 3'd3,
      REG_BAND_COUNT    = 3'd4,
      REG_DEST_X_BASE   = 3'd5,
      REG_DEST_Y_BASE   = 3'd6
   } csr_index_type;

endpackage

// ----- hw/rtl/line_scroll_blit_generator.sv -----
// Line scroll rectangle-move generator.
//
// Each item on the req_ channel carries one signed 4.4 scroll delta for the
// current band. The block adds it to that band's stored phase, turns the
// whole-pixel part of the phase into a rotation amount modulo the strip
// width, and returns two rectangle moves on the rsp_ channel that rotate
// the band: the first with rsp_last_of_pair low, the second with it high.
// Bands are taken in order; after the last band of a pass the band and row
// counters return to the first band.
//
// One item is in work at a time. After the item is accepted, the phase
// update state is followed by the divide state, in which a bit-serial
// remainder unit (the phase pattern modulo the strip width) and a
// bit-serial divider (band height) each retire one bit per step; the first
// move is then offered. The second move follows in the cycle after the first
// is taken, and req_ready returns in the cycle after the second is taken.
// While the receiver stalls, the pending move holds on the rsp_ ports and no
// new item is taken. After reset the phase memory is cleared one entry per
// cycle, every one of the MAX_BANDS entries, before req_ready first rises.
// Register writes may be made whenever the block is idle, even while clearing.
module line_scroll_blit_generator #(
   parameter int MAX_BANDS = 256
) (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [lsbg_pkg::DELTA_W-1:0]     req_scroll_delta,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic        [lsbg_pkg::COORD_W-1:0]     rsp_src_x,
   output logic        [lsbg_pkg::COORD_W-1:0]     rsp_src_y,
   output logic        [lsbg_pkg::SIZE_W-1:0]      rsp_rect_width,
   output logic        [lsbg_pkg::SIZE_W-1:0]      rsp_rect_height,
   output logic        [lsbg_pkg::COORD_W-1:0]     rsp_dst_x,
   output logic        [lsbg_pkg::COORD_W-1:0]     rsp_dst_y,
   output logic                                    rsp_last_of_pair,
   output logic                                    rsp_last_band,

   input  logic                                    csr_write,
   input  logic        [lsbg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [lsbg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lsbg_pkg::*;

   // Band index width, and a compare width wide enough for index + 1,
   // the raw band count and MAX_BANDS itself.
   localparam int IW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
   localparam int CW = ((IW + 1) > (COUNT_W + 1)) ? (IW + 1) : (COUNT_W + 1);
   localparam logic [IW-1:0] LAST_ADDR = IW'(MAX_BANDS - 1);
   localparam int STEP_W = $clog2(PHASE_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PHASE_W - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_FIRST,
      ST_SECOND
   } state_type;

   // Configuration registers.
   logic [XBASE_W-1:0] source_x_base_ff;
   logic [YBASE_W-1:0] source_y_base_ff;
   logic [MOD_W-1:0]   wrap_modulus_ff;
   logic [SPAN_W-1:0]  total_span_ff;
   logic [COUNT_W-1:0] band_count_ff;
   logic [XBASE_W-1:0] dest_x_base_ff;
   logic [YBASE_W-1:0] dest_y_base_ff;

   // Control state.
   state_type          state_ff;
   logic [IW-1:0]      clr_addr_ff;
   logic [IW-1:0]      band_index_ff;
   logic [COORD_W-1:0] row_offset_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               rsp_valid_ff;

   // Working registers of the item in flight.
   logic [DELTA_W-1:0] delta_ff;
   logic [PHASE_W-1:0] mem_rd_ff;
   logic [PHASE_W-1:0] pat_sh_ff;
   logic [MOD_W-1:0]   mod_rem_ff;
   logic [PHASE_W-1:0] span_sh_ff;
   logic [COUNT_W-1:0] span_rem_ff;
   logic [SIZE_W-1:0]  quot_ff;
   logic [SIZE_W-1:0]  r_ff;
   logic [SIZE_W-1:0]  off_ff;
   logic [SIZE_W-1:0]  h_ff;
   logic               last_ff;

   // Result registers.
   logic [COORD_W-1:0] rsp_src_x_ff;
   logic [COORD_W-1:0] rsp_src_y_ff;
   logic [SIZE_W-1:0]  rsp_rect_width_ff;
   logic [SIZE_W-1:0]  rsp_rect_height_ff;
   logic [COORD_W-1:0] rsp_dst_x_ff;
   logic [COORD_W-1:0] rsp_dst_y_ff;
   logic               rsp_last_of_pair_ff;
   logic               rsp_last_band_ff;

   // Phase memory, one 16-bit entry per band.
   logic [PHASE_W-1:0] phase_mem [MAX_BANDS];
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   logic [PHASE_W-1:0] mem_wdata;

   // Next values.
   logic [PHASE_W-1:0] phase_in;
   logic [PHASE_W-1:0] pat_in;
   logic               last_in;
   logic [MOD_W:0]     mod_trial;
   logic [MOD_W-1:0]   mod_rem_in;
   logic [COUNT_W:0]   span_trial;
   logic [COUNT_W-1:0] span_rem_in;
   logic [SIZE_W-1:0]  quot_in;
   logic [SIZE_W-1:0]  r_in;
   logic [SIZE_W-1:0]  off_in;
   logic [SIZE_W-1:0]  h_in;
   logic [CW-1:0]      pass_len;
   logic [CW-1:0]      count_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_x_base_ff <= '0;
         source_y_base_ff <= '0;
         wrap_modulus_ff  <= MOD_W'(1);
         total_span_ff    <= '0;
         band_count_ff    <= COUNT_W'(1);
         dest_x_base_ff   <= '0;
         dest_y_base_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SOURCE_X_BASE: source_x_base_ff <= csr_wdata[XBASE_W-1:0];
            REG_SOURCE_Y_BASE: source_y_base_ff <= csr_wdata[YBASE_W-1:0];
            REG_WRAP_MODULUS:  wrap_modulus_ff  <= csr_wdata[MOD_W-1:0];
            REG_TOTAL_SPAN:    total_span_ff    <= csr_wdata[SPAN_W-1:0];
            REG_BAND_COUNT:    band_count_ff    <= csr_wdata[COUNT_W-1:0];
            REG_DEST_X_BASE:   dest_x_base_ff   <= csr_wdata[XBASE_W-1:0];
            REG_DEST_Y_BASE:   dest_y_base_ff   <= csr_wdata[YBASE_W-1:0];
            default: ;
         endcase
      end
   end

   // The phase update adds the sign-extended delta; the whole-pixel pattern
   // is the phase shifted arithmetically right by the fraction width.
   assign phase_in = mem_rd_ff + {{(PHASE_W - DELTA_W){delta_ff[DELTA_W-1]}}, delta_ff};
   assign pat_in   = {{FRAC_W{phase_in[PHASE_W-1]}}, phase_in[PHASE_W-1:FRAC_W]};

   // A zero band count still makes a pass one band long; a count above the
   // memory depth is clamped to it.
   always_comb begin
      count_ext = CW'(band_count_ff);
      if (count_ext == '0) begin
         pass_len = CW'(1);
      end else if (count_ext > CW'(MAX_BANDS)) begin
         pass_len = CW'(MAX_BANDS);
      end else begin
         pass_len = count_ext;
      end
   end
   assign last_in = (CW'(band_index_ff) + CW'(1)) >= pass_len;

   // One restoring step of each serial unit per cycle.
   assign mod_trial  = {mod_rem_ff, pat_sh_ff[PHASE_W-1]};
   assign mod_rem_in = (mod_trial >= {1'b0, wrap_modulus_ff})
                     ? MOD_W'(mod_trial - {1'b0, wrap_modulus_ff})
                     : mod_trial[MOD_W-1:0];

   assign span_trial  = {span_rem_ff, span_sh_ff[PHASE_W-1]};
   assign span_rem_in = (span_trial >= {1'b0, band_count_ff})
                      ? COUNT_W'(span_trial - {1'b0, band_count_ff})
                      : span_trial[COUNT_W-1:0];
   assign quot_in     = {quot_ff[SIZE_W-2:0], (span_trial >= {1'b0, band_count_ff})};

   // A zero modulus gives no rotation, and a zero count gives zero height.
   assign r_in   = (wrap_modulus_ff == '0) ? '0 : mod_rem_in;
   assign off_in = wrap_modulus_ff - r_in;
   assign h_in   = (band_count_ff == '0) ? '0 : quot_in;

   always_comb begin
      mem_we    = (state_ff == ST_CLEAR) || (state_ff == ST_UPDATE);
      mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : band_index_ff;
      mem_wdata = (state_ff == ST_CLEAR) ? '0 : phase_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         phase_mem[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff <= phase_mem[band_index_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         band_index_ff <= '0;
         row_offset_ff <= '0;
         step_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + IW'(1);
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               // The memory read of the current band lands in mem_rd_ff at
               // this same edge.
               if (req_valid) begin
                  delta_ff <= req_scroll_delta;
                  state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               pat_sh_ff   <= pat_in;
               mod_rem_ff  <= '0;
               span_sh_ff  <= {{(PHASE_W - SPAN_W){1'b0}}, total_span_ff};
               span_rem_ff <= '0;
               quot_ff     <= '0;
               last_ff     <= last_in;
               step_ff     <= '0;
               state_ff    <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               pat_sh_ff   <= {pat_sh_ff[PHASE_W-2:0], 1'b0};
               mod_rem_ff  <= mod_rem_in;
               span_sh_ff  <= {span_sh_ff[PHASE_W-2:0], 1'b0};
               span_rem_ff <= span_rem_in;
               quot_ff     <= quot_in;
               step_ff     <= step_ff + STEP_W'(1);
               if (step_ff == LAST_STEP) begin
                  r_ff   <= r_in;
                  off_ff <= off_in;
                  h_ff   <= h_in;
                  // First move: the left part of width r lands after the
                  // right part.
                  rsp_src_x_ff        <= COORD_W'(source_x_base_ff);
                  rsp_src_y_ff        <= COORD_W'(source_y_base_ff) + row_offset_ff;
                  rsp_rect_width_ff   <= r_in;
                  rsp_rect_height_ff  <= h_in;
                  rsp_dst_x_ff        <= COORD_W'(dest_x_base_ff) + COORD_W'(off_in);
                  rsp_dst_y_ff        <= COORD_W'(dest_y_base_ff) + row_offset_ff;
                  rsp_last_of_pair_ff <= 1'b0;
                  rsp_last_band_ff    <= last_ff;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= ST_FIRST;
               end
            end
            ST_FIRST: begin
               if (rsp_ready) begin
                  rsp_src_x_ff        <= COORD_W'(source_x_base_ff) + COORD_W'(r_ff);
                  rsp_rect_width_ff   <= off_ff;
                  rsp_dst_x_ff        <= COORD_W'(dest_x_base_ff);
                  rsp_last_of_pair_ff <= 1'b1;
                  state_ff            <= ST_SECOND;
               end
            end
            ST_SECOND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (last_ff) begin
                     band_index_ff <= '0;
                     row_offset_ff <= '0;
                  end else begin
                     band_index_ff <= band_index_ff + IW'(1);
                     row_offset_ff <= row_offset_ff + COORD_W'(h_ff);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_src_x        = rsp_src_x_ff;
   assign rsp_src_y        = rsp_src_y_ff;
   assign rsp_rect_width   = rsp_rect_width_ff;
   assign rsp_rect_height  = rsp_rect_height_ff;
   assign rsp_dst_x        = rsp_dst_x_ff;
   assign rsp_dst_y        = rsp_dst_y_ff;
   assign rsp_last_of_pair = rsp_last_of_pair_ff;
   assign rsp_last_band    = rsp_last_band_ff;

endmodule
